@@ rtl/double_sha256_header_hasher_assert.svh @@
// ---------------------------------------------------------------------------
// sha256d assertion macros
// shared concurrent assertion forms for the hasher modules
// ---------------------------------------------------------------------------
`ifndef DOUBLE_SHA256_HEADER_HASHER_ASSERT_SVH
`define DOUBLE_SHA256_HEADER_HASHER_ASSERT_SVH

// implication checked on every edge outside reset
`define SHD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define SHD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/shd_pkg.sv @@
// ---------------------------------------------------------------------------
// sha256d package
// constants, round table, rotate helper function and control types
// ---------------------------------------------------------------------------
package shd_pkg;

  localparam int MSG_WORDS = 20;
  localparam int DIG_WORDS = 8;
  localparam int ROUNDS    = 64;

  localparam logic [31:0] PAD_WORD   = 32'h8000_0000;
  localparam logic [31:0] LEN_FIRST  = 32'd640;
  localparam logic [31:0] LEN_SECOND = 32'd256;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } shd_state_t;

  typedef enum logic [1:0] {
    BLK_MSG0,
    BLK_MSG1,
    BLK_DIG
  } shd_block_t;

  typedef struct packed {
    logic       store_word;
    logic       load_block;
    shd_block_t block_sel;
    logic       round_step;
    logic       fold;
    logic       init_chain;
    logic [2:0] emit_index;
  } shd_cmd_t;

  typedef struct packed {
    logic       last_input;
    logic       rounds_done;
  } shd_status_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ rtl/shd_ctrl.sv @@
// ---------------------------------------------------------------------------
// sha256d controller
// sequences word collection, three compressions and digest output
// ---------------------------------------------------------------------------
`include "double_sha256_header_hasher_assert.svh"

module shd_ctrl
  import shd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  output logic        out_valid,
  input  shd_status_t status,
  output shd_cmd_t    cmd
);

  shd_state_t state_r, state_nxt;
  shd_block_t blk_r, blk_nxt;
  logic [2:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
      blk_r   <= BLK_MSG0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      blk_r   <= blk_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    blk_nxt        = blk_r;
    idx_nxt        = idx_r;
    cmd            = '0;
    cmd.block_sel  = blk_r;
    cmd.emit_index = idx_r;
    busy           = 1'b1;
    out_valid      = 1'b0;
    unique case (state_r)
      ST_COLLECT: begin
        busy = 1'b0;
        if (start) begin
          cmd.store_word = 1'b1;
          if (status.last_input) begin
            state_nxt = ST_LOAD;
            blk_nxt   = BLK_MSG0;
          end
        end
      end
      ST_LOAD: begin
        cmd.load_block = 1'b1;
        cmd.init_chain = (blk_r != BLK_MSG1);
        state_nxt      = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round_step = 1'b1;
        if (status.rounds_done) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        unique case (blk_r)
          BLK_MSG0: begin
            blk_nxt   = BLK_MSG1;
            state_nxt = ST_LOAD;
          end
          BLK_MSG1: begin
            blk_nxt   = BLK_DIG;
            state_nxt = ST_LOAD;
          end
          default: begin
            idx_nxt   = '0;
            state_nxt = ST_EMIT;
          end
        endcase
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        idx_nxt   = idx_r + 3'd1;
        if (idx_r == 3'(DIG_WORDS - 1)) state_nxt = ST_COLLECT;
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  `SHD_ASSERT_IMP(a_busy_out, out_valid, busy, "result while idle")
  `SHD_ASSERT_NEXT(a_emit_len, out_valid && idx_r == 3'd7, state_r == ST_COLLECT,
    "emit did not end after eight words")
  `SHD_ASSERT_IMP(a_round_only, cmd.round_step, state_r == ST_ROUND, "stray round step")

endmodule

@@ rtl/shd_datapath.sv @@
// ---------------------------------------------------------------------------
// sha256d datapath
// message buffer, schedule window, round logic and chain value
// ---------------------------------------------------------------------------
module shd_datapath
  import shd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  shd_cmd_t    cmd,
  input  logic [31:0] in_message_word,
  output shd_status_t status,
  output logic [31:0] digest_word
);

  logic [31:0] msg_r [MSG_WORDS];
  logic [31:0] w_r [16];
  logic [31:0] v_r [8];
  logic [31:0] h_r [8];
  logic [4:0]  cnt_r;
  logic [5:0]  rnd_r;
  logic [31:0] blk [16];
  logic [31:0] w_new, s0, s1, t1, t2, e, a;

  assign status.last_input  = (cnt_r == 5'(MSG_WORDS - 1));
  assign status.rounds_done = (rnd_r == 6'(ROUNDS - 1));
  assign digest_word = h_r[cmd.emit_index];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rnd_r <= '0;
    end else begin
      if (cmd.store_word) cnt_r <= status.last_input ? 5'd0 : cnt_r + 5'd1;
      if (cmd.load_block) rnd_r <= '0;
      else if (cmd.round_step) rnd_r <= rnd_r + 6'd1;
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) blk[i] = '0;
    unique case (cmd.block_sel)
      BLK_MSG0: for (int i = 0; i < 16; i++) blk[i] = msg_r[i];
      BLK_MSG1: begin
        for (int i = 0; i < 4; i++) blk[i] = msg_r[16 + i];
        blk[4]  = PAD_WORD;
        blk[15] = LEN_FIRST;
      end
      default: begin
        for (int i = 0; i < 8; i++) blk[i] = h_r[i];
        blk[8]  = PAD_WORD;
        blk[15] = LEN_SECOND;
      end
    endcase
  end

  // window kept shifted: w_r[0] is the current word
  always_comb begin
    s0    = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1    = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = s1 + w_r[9] + s0 + w_r[0];
    e     = v_r[4];
    a     = v_r[0];
    t1 = v_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
       + ((e & v_r[5]) ^ (~e & v_r[6])) + K[rnd_r] + w_r[0];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
       + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (cmd.store_word) msg_r[cnt_r] <= in_message_word;
    if (cmd.load_block) begin
      for (int i = 0; i < 16; i++) w_r[i] <= blk[i];
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= cmd.init_chain ? IV[i] : h_r[i];
        if (cmd.init_chain) h_r[i] <= IV[i];
      end
    end else if (cmd.round_step) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= w_new;
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end else if (cmd.fold) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
  end

endmodule

@@ rtl/double_sha256_header_hasher.sv @@
// ---------------------------------------------------------------------------
// double sha256 header hasher
// sha256d of an 80-byte header given as twenty big-endian words
// ---------------------------------------------------------------------------
// usage:
//   drive in_message_word with start high while busy is low; each such
//   cycle takes one item. each word is stored in the message buffer, and
//   the twentieth word starts three compressions (two for the header,
//   one for the digest), each a load, 64 rounds and a fold, with one
//   round per cycle through a single round unit.
//   out_valid then stays high while out_digest_word carries the eight
//   digest words with out_digest_index 0..7; out_last_word marks index 7.
//   busy stays high from the cycle after the twentieth word to the last result.
//   the receiver cannot stall; results are not held.
//   reset clears the word count and returns the controller to collecting.
// ---------------------------------------------------------------------------
`include "double_sha256_header_hasher_assert.svh"

module double_sha256_header_hasher
  import shd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_message_word,
  output logic        out_valid,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_digest_index,
  output logic        out_last_word
);

  shd_cmd_t    cmd;
  shd_status_t status;

  shd_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .out_valid, .status, .cmd
  );

  shd_datapath u_dp (
    .clk, .rst_n, .cmd, .in_message_word, .status,
    .digest_word(out_digest_word)
  );

  assign out_digest_index = cmd.emit_index;
  assign out_last_word    = out_valid && (cmd.emit_index == 3'(DIG_WORDS - 1));

  `SHD_ASSERT_IMP(a_last_idx, out_last_word, out_digest_index == 3'd7, "last flag misplaced")
  `SHD_ASSERT_NEXT(a_idx_step, out_valid && !out_last_word,
    out_valid && out_digest_index == $past(out_digest_index) + 3'd1, "index skipped")
  `SHD_ASSERT_IMP(a_no_take, busy, !cmd.store_word, "item taken while busy")

endmodule

@@ tb/double_sha256_header_hasher_tb.sv @@
// ---------------------------------------------------------------------------
// double sha256 header hasher testbench
// feeds twenty-word headers through start and in_message_word, with random gaps in some runs,
// predicts the sha256d digest of each header and checks every digest word
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module double_sha256_header_hasher_tb
  import shd_pkg::*;
();

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_message_word;
  logic        out_valid;
  logic [31:0] out_digest_word;
  logic [2:0]  out_digest_index;
  logic        out_last_word;

  logic [31:0]  pending_words[$];
  digest_item_t expected_digest[$];
  logic [31:0]  header_buf[MSG_WORDS];
  int           header_fill;
  int           idle_pct;
  int           error_count;
  int           words_sent;
  int           digests_seen;

  double_sha256_header_hasher u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_message_word  (in_message_word),
    .out_valid        (out_valid),
    .out_digest_word  (out_digest_word),
    .out_digest_index (out_digest_index),
    .out_last_word    (out_last_word)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void sha_block(ref logic [31:0] hv[8], input logic [31:0] blk[16]);
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2, s0, s1;
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w[t] = blk[t];
      end else begin
        s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
        s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
        w[t] = s1 + w[t-7] + s0 + w[t-16];
      end
    end
    v = hv;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K[t] + w[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hv[i] += v[i];
  endfunction

  // takes one accepted word; a full header queues its eight digest words
  function automatic void absorb_header_word(input logic [31:0] word);
    logic [31:0] hv[8];
    logic [31:0] blk[16];
    digest_item_t d;
    header_buf[header_fill] = word;
    header_fill++;
    if (header_fill < MSG_WORDS) return;
    header_fill = 0;
    for (int i = 0; i < 8; i++) hv[i] = IV[i];
    for (int i = 0; i < 16; i++) blk[i] = header_buf[i];
    sha_block(hv, blk);
    for (int i = 0; i < 16; i++) blk[i] = '0;
    for (int i = 0; i < 4; i++) blk[i] = header_buf[16+i];
    blk[4] = PAD_WORD;
    blk[15] = LEN_FIRST;
    sha_block(hv, blk);
    for (int i = 0; i < 16; i++) blk[i] = '0;
    for (int i = 0; i < 8; i++) blk[i] = hv[i];
    blk[8] = PAD_WORD;
    blk[15] = LEN_SECOND;
    for (int i = 0; i < 8; i++) hv[i] = IV[i];
    sha_block(hv, blk);
    for (int i = 0; i < 8; i++) begin
      d.word = hv[i];
      d.index = 3'(i);
      d.last = (i == 7);
      expected_digest.push_back(d);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_message_word <= '0;
    end else begin
      if (start && !busy) begin
        absorb_header_word(in_message_word);
        words_sent++;
      end
      if ((!start || !busy) && pending_words.size() > 0 &&
          $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        in_message_word <= pending_words.pop_front();
      end else if (!start || !busy) begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    digest_item_t d;
    if (rst_n && out_valid) begin
      if (expected_digest.size() == 0) begin
        $error("unexpected digest word %h", out_digest_word);
        error_count++;
      end else begin
        d = expected_digest.pop_front();
        digests_seen++;
        if (out_digest_word !== d.word) begin
          $error("digest_word expected %h actual %h", d.word, out_digest_word);
          error_count++;
        end
        if (out_digest_index !== d.index) begin
          $error("digest_index expected %0d actual %0d", d.index, out_digest_index);
          error_count++;
        end
        if (out_last_word !== d.last) begin
          $error("last_word expected %0d actual %0d", d.last, out_last_word);
          error_count++;
        end
      end
    end
  end

  task automatic queue_header(input int kind);
    for (int i = 0; i < MSG_WORDS; i++) begin
      case (kind)
        0: pending_words.push_back(32'h0000_0000);
        1: pending_words.push_back(32'hffff_ffff);
        2: pending_words.push_back((i % 2) ? 32'haaaa_aaaa : 32'h5555_5555);
        default: pending_words.push_back($urandom);
      endcase
    end
  endtask

  task automatic drain_queue();
    while (pending_words.size() > 0 || start) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_message_word = '0;
    header_fill = 0;
    error_count = 0;
    words_sent = 0;
    digests_seen = 0;
    idle_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // directed headers: all zero, all one, alternating bits
    queue_header(0);
    queue_header(1);
    queue_header(2);
    drain_queue();
    idle_pct = 31;
    for (int m = 0; m < 8; m++) queue_header(3);
    drain_queue();
    idle_pct = 63;
    for (int m = 0; m < 8; m++) queue_header(3);
    drain_queue();
    idle_pct = 0;
    for (int m = 0; m < 5; m++) queue_header(3);
    drain_queue();
    while (expected_digest.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d header words, checked %0d digest words", words_sent,
             digests_seen);
    $display("directed zero, one and alternating headers plus random ones");
    if (error_count == 0 && expected_digest.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/shd_pkg.sv
rtl/shd_ctrl.sv
rtl/shd_datapath.sv
rtl/double_sha256_header_hasher.sv
tb/double_sha256_header_hasher_tb.sv
